// ===== hdl/clr_pkg.sv =====
package clr_pkg;

  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 270;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ON         = 3'd6;

  typedef struct packed {
    logic signed [14:0] camera_offset_x;
    logic signed [14:0] camera_offset_y;
    logic signed [14:0] clip_left;
    logic signed [14:0] clip_top;
    logic        [13:0] clip_width;
    logic        [13:0] clip_height;
    logic               clip_on;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] current_x;
    logic signed [15:0] current_y;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [15:0] delta_x;
    logic        [15:0] delta_y;
    logic               step_x_negative;
    logic               step_y_negative;
    logic signed [17:0] error_term;
    logic        [7:0]  held_color;
    logic               line_active;
  } line_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic        [7:0]  pixel_color;
    logic               write_enable;
    logic               last_pixel;
  } pixel_t;

endpackage

// ===== hdl/clr_cfg_regs.sv =====
module clr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [clr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output clr_pkg::cfg_t                      cfg
);

  clr_pkg::cfg_t cfg_r;
  clr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        clr_pkg::REG_CAMERA_OFFSET_X: cfg_nxt.camera_offset_x = $signed(cfg_data);
        clr_pkg::REG_CAMERA_OFFSET_Y: cfg_nxt.camera_offset_y = $signed(cfg_data);
        clr_pkg::REG_CLIP_LEFT:       cfg_nxt.clip_left       = $signed(cfg_data);
        clr_pkg::REG_CLIP_TOP:        cfg_nxt.clip_top        = $signed(cfg_data);
        clr_pkg::REG_CLIP_WIDTH:      cfg_nxt.clip_width      = cfg_data[13:0];
        clr_pkg::REG_CLIP_HEIGHT:     cfg_nxt.clip_height     = cfg_data[13:0];
        clr_pkg::REG_CLIP_ON:         cfg_nxt.clip_on         = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/clr_setup.sv =====
module clr_setup (
  input  logic signed [14:0] start_x,
  input  logic signed [14:0] start_y,
  input  logic signed [14:0] end_x,
  input  logic signed [14:0] end_y,
  input  logic        [7:0]  line_color,
  input  clr_pkg::cfg_t      cfg,
  output clr_pkg::line_t     line
);

  logic signed [15:0] x1, y1, x2, y2;
  logic signed [16:0] diff_x, diff_y;
  logic               x_fwd, y_fwd;
  logic        [15:0] dx, dy;

  assign x1 = 16'(start_x) - 16'(cfg.camera_offset_x);
  assign y1 = 16'(start_y) - 16'(cfg.camera_offset_y);
  assign x2 = 16'(end_x) - 16'(cfg.camera_offset_x);
  assign y2 = 16'(end_y) - 16'(cfg.camera_offset_y);

  assign diff_x = 17'(x2) - 17'(x1);
  assign diff_y = 17'(y2) - 17'(y1);
  assign x_fwd  = x1 < x2;
  assign y_fwd  = y1 < y2;
  assign dx     = x_fwd ? diff_x[15:0] : 16'(-diff_x);
  assign dy     = y_fwd ? diff_y[15:0] : 16'(-diff_y);

  always_comb begin
    line.current_x       = x1;
    line.current_y       = y1;
    line.target_x        = x2;
    line.target_y        = y2;
    line.delta_x         = dx;
    line.delta_y         = dy;
    line.step_x_negative = !x_fwd;
    line.step_y_negative = !y_fwd;
    line.error_term      = $signed({2'b00, dx}) - $signed({2'b00, dy});
    line.held_color      = line_color;
    line.line_active     = 1'b1;
  end

endmodule

// ===== hdl/clr_step.sv =====
module clr_step (
  input  clr_pkg::line_t  line,
  input  clr_pkg::cfg_t   cfg,
  output clr_pkg::pixel_t pixel,
  output clr_pkg::line_t  line_adv
);

  logic signed [18:0] e2, dx_w, dy_w, err_w, err_new;
  logic               move_x, move_y, last;
  logic               on_screen, in_clip;
  logic signed [16:0] x_w, y_w, left_w, top_w, right_w, bottom_w;

  assign e2     = {line.error_term, 1'b0};
  assign dx_w   = $signed({3'b000, line.delta_x});
  assign dy_w   = $signed({3'b000, line.delta_y});
  assign err_w  = 19'(line.error_term);
  assign move_x = e2 > -dy_w;
  assign move_y = e2 < dx_w;
  assign err_new = err_w - (move_x ? dy_w : 19'sd0) + (move_y ? dx_w : 19'sd0);

  assign last = (line.current_x == line.target_x) && (line.current_y == line.target_y);

  assign x_w      = 17'(line.current_x);
  assign y_w      = 17'(line.current_y);
  assign left_w   = 17'(cfg.clip_left);
  assign top_w    = 17'(cfg.clip_top);
  assign right_w  = left_w + $signed({3'b000, cfg.clip_width});
  assign bottom_w = top_w + $signed({3'b000, cfg.clip_height});

  assign on_screen = !line.current_x[15] && !line.current_y[15] &&
                     (x_w < $signed(17'(clr_pkg::SCREEN_WIDTH))) &&
                     (y_w < $signed(17'(clr_pkg::SCREEN_HEIGHT)));
  assign in_clip   = (x_w >= left_w) && (x_w < right_w) &&
                     (y_w >= top_w) && (y_w < bottom_w);

  always_comb begin
    pixel.pixel_x      = line.current_x;
    pixel.pixel_y      = line.current_y;
    pixel.pixel_color  = line.held_color;
    pixel.write_enable = on_screen && (!cfg.clip_on || in_clip);
    pixel.last_pixel   = last;

    line_adv = line;
    if (last) begin
      line_adv.line_active = 1'b0;
    end else begin
      line_adv.error_term = err_new[17:0];
      if (move_x) begin
        line_adv.current_x = line.current_x + (line.step_x_negative ? -16'sd1 : 16'sd1);
      end
      if (move_y) begin
        line_adv.current_y = line.current_y + (line.step_y_negative ? -16'sd1 : 16'sd1);
      end
    end
  end

endmodule

// ===== hdl/clipped_line_rasterizer.sv =====
// Line draw engine that turns two endpoints into a stream of frame buffer pixels.
// The input channel (in_valid/in_ready) carries one request per item. A start
// request (in_operation = 0) loads both endpoints, shifted by the camera offset,
// and the line color; it produces no output. Each step request (in_operation = 1)
// produces one pixel on the output channel (out_valid/out_ready) with its screen
// coordinates, color, write enable and a last flag on the final endpoint, after
// which the engine is idle and further steps produce nothing.
// Each accepted step writes its pixel into the output register; one request can
// be accepted each cycle while that register is empty or being drained, so a
// line of N pixels streams out at one pixel per clock when the receiver does
// not stall. The Bresenham state update is a single add-and-compare stage that
// closes on itself through the line register. A stalled output register holds
// its pixel; in_ready is high only while it is empty or freed in the same cycle.
// The cfg_we/cfg_index/cfg_data port writes the camera and clip registers; the
// camera offset is sampled at start, the clip window is checked at every step.
// A synchronous reset (rst_n low) clears all but pixel_r; the engine is idle.
module clipped_line_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [clr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic signed [14:0]                 in_start_x,
  input  logic signed [14:0]                 in_start_y,
  input  logic signed [14:0]                 in_end_x,
  input  logic signed [14:0]                 in_end_y,
  input  logic        [7:0]                  in_line_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_pixel_x,
  output logic signed [15:0]                 out_pixel_y,
  output logic        [7:0]                  out_pixel_color,
  output logic                               out_write_enable,
  output logic                               out_last_pixel
);

  clr_pkg::cfg_t   cfg;
  clr_pkg::line_t  line_r, line_nxt, line_start, line_adv;
  clr_pkg::pixel_t pixel, pixel_r, pixel_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  clr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clr_setup u_setup (
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .cfg        (cfg),
    .line       (line_start)
  );

  clr_step u_step (
    .line     (line_r),
    .cfg      (cfg),
    .pixel    (pixel),
    .line_adv (line_adv)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    line_nxt      = line_r;
    pixel_nxt     = pixel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      if (in_operation == clr_pkg::OP_START) begin
        line_nxt = line_start;
      end else if (line_r.line_active) begin
        line_nxt      = line_adv;
        pixel_nxt     = pixel;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = pixel_r.pixel_x;
  assign out_pixel_y      = pixel_r.pixel_y;
  assign out_pixel_color  = pixel_r.pixel_color;
  assign out_write_enable = pixel_r.write_enable;
  assign out_last_pixel   = pixel_r.last_pixel;

endmodule
